// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("lbl");

// Whenever a holds, b holds in the same cycle.
`define ASSERT_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");

`endif

// ===== hw/rtl/rgpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ground plane intersection package
// Widths, codes and the item types handed along the division and root chains.
// ----------------------------------------------------------------------------
package rgpi_pkg;

  localparam int WORD_BITS  = 32;
  localparam int MIN_DZ_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_W      = 2 * WORD_BITS + 1;
  localparam int DEN_W      = WORD_BITS + 1;
  localparam int REM_W      = WORD_BITS + 2;
  localparam int Q_W        = WORD_BITS + 2;
  localparam int DIV_CELLS  = NUM_W;
  localparam int SUM_W      = 2 * WORD_BITS + 2;
  localparam int ROOT_W     = WORD_BITS + 1;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int SQRT_CELLS = ROOT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_Z  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIR_Z = 2'd1;

  localparam logic [Q_W-1:0] Q_LIM = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_BEHIND   = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    logic                        valid;
    status_t                     status;
    logic signed [WORD_BITS-1:0] ox;
    logic signed [WORD_BITS-1:0] oy;
    logic                        negx;
    logic                        negy;
    logic [WORD_BITS:0]          an;
  } div_side_t;

  typedef struct packed {
    div_side_t        side;
    logic [DEN_W-1:0] den;
    div_lane_t        lx;
    div_lane_t        ly;
  } div_word_t;

  typedef struct packed {
    logic                        valid;
    status_t                     status;
    logic signed [WORD_BITS-1:0] hx;
    logic signed [WORD_BITS-1:0] hy;
    logic                        sat;
    logic                        big;
  } sq_side_t;

  typedef struct packed {
    sq_side_t          side;
    logic [SUM_W-1:0]  val;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_word_t;

  typedef struct packed {
    status_t                     status;
    logic signed [WORD_BITS-1:0] hit_x;
    logic signed [WORD_BITS-1:0] hit_y;
    logic [WORD_BITS-1:0]        range_dist;
    logic                        saturated;
  } res_t;

endpackage

// ===== hw/rtl/rgpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step for the x and y lanes, registered.
// ----------------------------------------------------------------------------
module rgpi_div_cell import rgpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_word_t din,
  output div_word_t dout
);

  div_word_t nxt;

  function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] den);
    div_lane_t        r;
    logic [REM_W-1:0] trial;
    trial = {l.rem[REM_W-2:0], l.num[NUM_W-1]};
    r.num = {l.num[NUM_W-2:0], 1'b0};
    r.ovf = l.ovf | l.quo[Q_W-1];
    if (trial >= REM_W'(den)) begin
      r.rem = trial - REM_W'(den);
      r.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      r.rem = trial;
      r.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    nxt.side = din.side;
    nxt.den  = din.den;
    nxt.lx   = div_step(din.lx, din.den);
    nxt.ly   = div_step(din.ly, din.den);
  end

  always_ff @(posedge clk) begin
    if (rst) dout.side.valid <= 1'b0;
    else if (en) dout <= nxt;
  end

endmodule

// ===== hw/rtl/rgpi_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a bitwise integer square root, registered.
// ----------------------------------------------------------------------------
module rgpi_sqrt_cell import rgpi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  sq_word_t din,
  output sq_word_t dout
);

  sq_word_t          nxt;
  logic [SREM_W-1:0] trial_rem;
  logic [SREM_W-1:0] trial;

  always_comb begin
    trial_rem = {din.rem[SREM_W-3:0], din.val[SUM_W-1:SUM_W-2]};
    trial     = SREM_W'({din.root, 2'b01});
    nxt.side  = din.side;
    nxt.val   = {din.val[SUM_W-3:0], 2'b00};
    if (trial_rem >= trial) begin
      nxt.rem  = trial_rem - trial;
      nxt.root = {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = trial_rem;
      nxt.root = {din.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout.side.valid <= 1'b0;
    else if (en) dout <= nxt;
  end

endmodule

// ===== hw/rtl/rgpi_out_buf.sv =====
// ----------------------------------------------------------------------------
// Output buffer
// Two-entry result queue that lets the pipeline run while results wait.
// ----------------------------------------------------------------------------
module rgpi_out_buf import rgpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t dout
);

  res_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign dout      = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/ray_ground_plane_intersect.sv =====
// ----------------------------------------------------------------------------
// Ray to ground plane intersection
// Intersects one Q16.16 ray per cycle with the plane z = ground_z, unless the input is stalled.
// ----------------------------------------------------------------------------
// The block takes one ray every cycle while not stalled and returns one result
// per ray, in order, after two input stages, a chain of 65 restoring division
// cells that forms both scaled displacements, two stages for the sums and
// squares, a chain of 33 square root cells for the range, and an output stage.
// A two-entry output queue holds results; the input stalls only while it is full.
module ray_ground_plane_intersect import rgpi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [WORD_BITS-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] start_x,
  input  logic signed [WORD_BITS-1:0] start_y,
  input  logic signed [WORD_BITS-1:0] start_z,
  input  logic signed [WORD_BITS-1:0] dir_x,
  input  logic signed [WORD_BITS-1:0] dir_y,
  input  logic signed [WORD_BITS-1:0] dir_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic signed [WORD_BITS-1:0] hit_x,
  output logic signed [WORD_BITS-1:0] hit_y,
  output logic [WORD_BITS-1:0]        range_dist,
  output logic                        saturated
);

  `include "assert_macros.svh"

  localparam int W = WORD_BITS;

  logic signed [W-1:0]   ground_z;
  logic [MIN_DZ_W-1:0]   min_dz;
  logic                  adv;
  logic                  buf_full;
  logic                  push;
  res_t                  res;
  res_t                  res_out;

  assign cfg_ready = 1'b1;
  assign adv       = !buf_full;
  assign in_stall  = buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_z <= '0;
      min_dz   <= MIN_DZ_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GROUND_Z) ground_z <= cfg_data;
      else if (cfg_index == CFG_MIN_DIR_Z) min_dz <= cfg_data[MIN_DZ_W-1:0];
    end
  end

  logic                v0;
  logic signed [W-1:0] ox0, oy0, dx0, dy0, dz0;
  logic signed [W:0]   num0;

  always_ff @(posedge clk) begin
    if (adv) begin
      ox0  <= start_x;
      oy0  <= start_y;
      dx0  <= dir_x;
      dy0  <= dir_y;
      dz0  <= dir_z;
      num0 <= (W+1)'(ground_z) - (W+1)'(start_z);
    end
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
  end

  logic [W-1:0] adx0, ady0, adz0;
  logic [W:0]   an0;
  status_t      st0;

  always_comb begin
    adx0 = dx0[W-1] ? (~dx0 + 1'b1) : dx0;
    ady0 = dy0[W-1] ? (~dy0 + 1'b1) : dy0;
    adz0 = dz0[W-1] ? (~dz0 + 1'b1) : dz0;
    an0  = num0[W] ? (~num0 + 1'b1) : num0;
    if (dz0 == '0 || adz0 < W'(min_dz)) st0 = ST_PARALLEL;
    else if ((num0 != '0) && (num0[W] == dz0[W-1])) st0 = ST_HIT;
    else st0 = ST_BEHIND;
  end

  div_side_t      side1;
  logic [2*W-1:0] plx1, ply1;
  logic [W-1:0]   adx1, ady1, adz1;

  always_ff @(posedge clk) begin
    if (adv) begin
      side1.status <= st0;
      side1.ox     <= ox0;
      side1.oy     <= oy0;
      side1.negx   <= dx0[W-1];
      side1.negy   <= dy0[W-1];
      side1.an     <= an0;
      plx1         <= an0[W-1:0] * adx0;
      ply1         <= an0[W-1:0] * ady0;
      adx1         <= adx0;
      ady1         <= ady0;
      adz1         <= adz0;
    end
    if (rst) side1.valid <= 1'b0;
    else if (adv) side1.valid <= v0;
  end

  div_word_t      div_w [DIV_CELLS+1];
  logic [2*W-1:0] px1, py1;

  always_comb begin
    px1 = plx1 + (side1.an[W] ? {adx1, {W{1'b0}}} : '0);
    py1 = ply1 + (side1.an[W] ? {ady1, {W{1'b0}}} : '0);
    div_w[0].side   = side1;
    div_w[0].den    = {adz1, 1'b0};
    div_w[0].lx.num = NUM_W'({px1, 1'b0}) + NUM_W'(adz1);
    div_w[0].lx.rem = '0;
    div_w[0].lx.quo = '0;
    div_w[0].lx.ovf = 1'b0;
    div_w[0].ly.num = NUM_W'({py1, 1'b0}) + NUM_W'(adz1);
    div_w[0].ly.rem = '0;
    div_w[0].ly.quo = '0;
    div_w[0].ly.ovf = 1'b0;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    rgpi_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (div_w[i]),
      .dout (div_w[i+1])
    );
  end

  div_word_t           dq;
  logic [Q_W-1:0]      qx, qy;
  logic signed [W+2:0] vx, vy;
  logic signed [W-1:0] hx2, hy2;
  logic                satx, saty;

  function automatic logic signed [W+2:0] sum_disp(logic signed [W-1:0] o,
                                                   logic [Q_W-1:0] m, logic neg);
    logic signed [W+2:0] oe;
    logic signed [W+2:0] me;
    oe = (W+3)'(o);
    me = signed'((W+3)'(m));
    return neg ? oe - me : oe + me;
  endfunction

  always_comb begin
    dq   = div_w[DIV_CELLS];
    qx   = (dq.lx.ovf || (dq.lx.quo[Q_W-1] && |dq.lx.quo[Q_W-2:0])) ? Q_LIM : dq.lx.quo;
    qy   = (dq.ly.ovf || (dq.ly.quo[Q_W-1] && |dq.ly.quo[Q_W-2:0])) ? Q_LIM : dq.ly.quo;
    vx   = sum_disp(dq.side.ox, qx, dq.side.negx);
    vy   = sum_disp(dq.side.oy, qy, dq.side.negy);
    satx = !((vx[W+2:W-1] == '0) || (vx[W+2:W-1] == '1));
    saty = !((vy[W+2:W-1] == '0) || (vy[W+2:W-1] == '1));
    hx2  = satx ? (vx[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : vx[W-1:0];
    hy2  = saty ? (vy[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : vy[W-1:0];
  end

  sq_side_t     side3;
  logic [W-1:0] qx3, qy3, an3;

  always_ff @(posedge clk) begin
    if (adv) begin
      side3.status <= dq.side.status;
      side3.hx     <= hx2;
      side3.hy     <= hy2;
      side3.sat    <= satx || saty;
      side3.big    <= (qx[Q_W-1:W] != '0) || (qy[Q_W-1:W] != '0) || dq.side.an[W];
      qx3          <= qx[W-1:0];
      qy3          <= qy[W-1:0];
      an3          <= dq.side.an[W-1:0];
    end
    if (rst) side3.valid <= 1'b0;
    else if (adv) side3.valid <= dq.side.valid;
  end

  sq_side_t       side4;
  logic [2*W-1:0] sx4, sy4, sz4;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4   <= qx3 * qx3;
      sy4   <= qy3 * qy3;
      sz4   <= an3 * an3;
    end
    if (rst) side4.valid <= 1'b0;
    else if (adv) side4 <= side3;
  end

  sq_word_t sq_w [SQRT_CELLS+1];

  always_comb begin
    sq_w[0].side = side4;
    sq_w[0].val  = SUM_W'(sx4) + SUM_W'(sy4) + SUM_W'(sz4);
    sq_w[0].rem  = '0;
    sq_w[0].root = '0;
  end

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    rgpi_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .din  (sq_w[j]),
      .dout (sq_w[j+1])
    );
  end

  sq_word_t sq_last;
  logic     rng_sat;

  always_comb begin
    sq_last = sq_w[SQRT_CELLS];
    rng_sat = sq_last.side.big || sq_last.root[ROOT_W-1];
    res.status = sq_last.side.status;
    if (sq_last.side.status == ST_HIT) begin
      res.hit_x      = sq_last.side.hx;
      res.hit_y      = sq_last.side.hy;
      res.range_dist = rng_sat ? '1 : sq_last.root[W-1:0];
      res.saturated  = sq_last.side.sat || rng_sat;
    end else begin
      res.hit_x      = '0;
      res.hit_y      = '0;
      res.range_dist = '0;
      res.saturated  = 1'b0;
    end
  end

  assign push = adv && sq_last.side.valid;

  rgpi_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign status     = res_out.status;
  assign hit_x      = res_out.hit_x;
  assign hit_y      = res_out.hit_y;
  assign range_dist = res_out.range_dist;
  assign saturated  = res_out.saturated;

  `ASSERT_IMPLIES(a_miss_zero, out_valid && (status != ST_HIT),
                  (hit_x == '0) && (hit_y == '0) && (range_dist == '0) && !saturated)
  `ASSERT_IMPLIES(a_stall_has_item, in_stall, out_valid)
  `ASSERT_IMPLIES(a_reset_empty, $past(rst), !out_valid)

endmodule
